### design/r2y422_pkg.sv
`default_nettype none

package r2y422_pkg;

  // Configuration register indexes
  localparam logic [7:0] RegSourceOrder = 8'd0;
  localparam logic [7:0] RegDestOrder   = 8'd1;

  // Input byte orders
  localparam logic SrcArgb = 1'b0;
  localparam logic SrcBgra = 1'b1;

  // Output byte orders
  localparam logic DstYuyv = 1'b0;
  localparam logic DstUyvy = 1'b1;

  // BT.709 integer coefficients and offsets
  localparam logic signed [17:0] CoefYR = 18'sd47;
  localparam logic signed [17:0] CoefYG = 18'sd157;
  localparam logic signed [17:0] CoefYB = 18'sd16;
  localparam logic signed [17:0] CoefUR = -18'sd26;
  localparam logic signed [17:0] CoefUG = -18'sd87;
  localparam logic signed [17:0] CoefUB = 18'sd112;
  localparam logic signed [17:0] CoefVR = 18'sd112;
  localparam logic signed [17:0] CoefVG = -18'sd102;
  localparam logic signed [17:0] CoefVB = -18'sd10;
  localparam logic signed [10:0] OffsetY = 11'sd16;
  localparam logic signed [10:0] OffsetC = 11'sd128;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Pick the colour bytes of one pixel; alpha is dropped
  function automatic rgb_t split_pixel(input logic [31:0] px, input logic order);
    rgb_t c;
    if (order == SrcArgb) begin
      c.r = px[15:8];
      c.g = px[23:16];
      c.b = px[31:24];
    end else begin
      c.b = px[7:0];
      c.g = px[15:8];
      c.r = px[23:16];
    end
    return c;
  endfunction

  // Dot product, floor shift by 8, offset and clamp to 0..255
  function automatic logic [7:0] component(input rgb_t c,
                                           input logic signed [17:0] kr,
                                           input logic signed [17:0] kg,
                                           input logic signed [17:0] kb,
                                           input logic signed [10:0] offset);
    logic signed [17:0] rs;
    logic signed [17:0] gs;
    logic signed [17:0] bs;
    logic signed [17:0] sum;
    logic signed [10:0] biased;
    logic [7:0] res;
    rs = $signed({10'd0, c.r});
    gs = $signed({10'd0, c.g});
    bs = $signed({10'd0, c.b});
    sum = rs * kr + gs * kg + bs * kb;
    // Arithmetic shift by 8 floors; take the top ten bits sign-extended
    biased = $signed({sum[17], sum[17:8]}) + offset;
    if (biased < 11'sd0) begin
      res = 8'd0;
    end else if (biased > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = biased[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/rgb_to_yuv422_bt709_unit.sv
// RGB to YCbCr 4:2:2 converter with BT.709 integer coefficients.
// Slave stream: s_axis_tdata carries two 32-bit pixels (first in bits 31:0),
// s_axis_tlast marks the last pair of a line or frame. Master stream:
// m_axis_tdata carries one packed 4:2:2 word, m_axis_tlast copies the flag.
// Each pixel gets its own Y; U and V come from the first pixel only.
// Config port: cfg_index_i 0 selects input byte order (0 ARGB, 1 BGRA),
// index 1 selects output order (0 YUYV, 1 UYVY); only bit 0 of the data is
// used and other indexes are ignored. cfg_ready_o is always high; write
// only while no beat is in flight.
// Each beat passes two register stages, the input register and the result
// register, before it is offered on the master side.
// Throughput: one pair per clock unless the receiver stalls; all maths is
// one pass of constant multiplies and adds between the two registers.
// Reset clears both byte-order registers and empties both stages.
// When the receiver stalls, the result register holds and the input
// register still fills once, so two beats can be held before s_axis_tready
// drops.
`default_nettype none

module rgb_to_yuv422_bt709_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] first_pixel, [63:32] second_pixel
  input  wire logic        s_axis_tlast,   // last_pair
  // Master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] packed_word
  output logic             m_axis_tlast,   // last_word
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic        source_order_q;
  logic        dest_order_q;
  logic        in_valid_q;
  logic [31:0] first_q;
  logic [31:0] second_q;
  logic        in_last_q;
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_last_q;
  logic        out_ready;
  logic        in_load;
  logic [31:0] word_d;

  r2y422_pkg::rgb_t px0;
  r2y422_pkg::rgb_t px1;
  logic [7:0] y0;
  logic [7:0] y1;
  logic [7:0] u;
  logic [7:0] v;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_order_q <= r2y422_pkg::SrcArgb;
      dest_order_q   <= r2y422_pkg::DstYuyv;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        r2y422_pkg::RegSourceOrder: source_order_q <= cfg_data_i[0];
        r2y422_pkg::RegDestOrder:   dest_order_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Flow control: result register frees when empty or taken
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_load       = !in_valid_q || out_ready;
  assign s_axis_tready = in_load;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid) begin
      first_q   <= s_axis_tdata[31:0];
      second_q  <= s_axis_tdata[63:32];
      in_last_q <= s_axis_tlast;
    end
  end

  // Convert one pair
  always_comb begin
    px0 = r2y422_pkg::split_pixel(first_q, source_order_q);
    px1 = r2y422_pkg::split_pixel(second_q, source_order_q);
    y0  = r2y422_pkg::component(px0, r2y422_pkg::CoefYR, r2y422_pkg::CoefYG,
                                r2y422_pkg::CoefYB, r2y422_pkg::OffsetY);
    y1  = r2y422_pkg::component(px1, r2y422_pkg::CoefYR, r2y422_pkg::CoefYG,
                                r2y422_pkg::CoefYB, r2y422_pkg::OffsetY);
    u   = r2y422_pkg::component(px0, r2y422_pkg::CoefUR, r2y422_pkg::CoefUG,
                                r2y422_pkg::CoefUB, r2y422_pkg::OffsetC);
    v   = r2y422_pkg::component(px0, r2y422_pkg::CoefVR, r2y422_pkg::CoefVG,
                                r2y422_pkg::CoefVB, r2y422_pkg::OffsetC);
    case (dest_order_q)
      r2y422_pkg::DstYuyv: word_d = {v, y1, u, y0};
      r2y422_pkg::DstUyvy: word_d = {y1, v, y0, u};
      default:             word_d = {v, y1, u, y0};
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_data_q <= word_d;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_ready |=> m_axis_tvalid)
    else $error("held pair did not reach the result register");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_ready |=> m_axis_tlast == $past(in_last_q))
    else $error("last flag lost between stages");

  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> (y0 >= 8'd16 && y0 <= 8'd235 && y1 >= 8'd16 && y1 <= 8'd235))
    else $error("luma outside 16..235");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == r2y422_pkg::RegSourceOrder
      |=> source_order_q == $past(cfg_data_i[0]))
    else $error("source order write not taken");

endmodule

`default_nettype wire

### verif/tb_rgb_to_yuv422_bt709_unit.sv
`timescale 1ns / 1ps

module tb_rgb_to_yuv422_bt709_unit;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;
  localparam int IdlePercent   = 21;
  localparam int PhaseBeats    = 410;

  // Indexes outside the register map; writes there must change nothing
  localparam logic [7:0] RegFirstUnused = 8'd2;
  localparam logic [7:0] RegLastIndex   = 8'hFF;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } yuv_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Shadow copy of the byte-order registers
  logic        src_order;
  logic        dst_order;
  logic        idle_on;
  int          error_count;
  int          quiet_cycles;
  yuv_beat_t   yuv_expected[$];

  rgb_to_yuv422_bt709_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Dot product, floor divide by 256, offset and clamp to a byte
  function automatic logic [7:0] bt709_component(input logic [7:0] r, g, b,
                                                 input int kr, kg, kb, offset);
    int acc;
    acc = kr * int'(r) + kg * int'(g) + kb * int'(b);
    acc = (acc >>> 8) + offset;
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  function automatic logic [31:0] yuv422_word(input logic [31:0] px0, px1,
                                              input logic src, dst);
    logic [7:0] r0, g0, b0, r1, g1, b1;
    logic [7:0] y0, y1, u, v;
    if (src == r2y422_pkg::SrcArgb) begin
      {b0, g0, r0} = px0[31:8];
      {b1, g1, r1} = px1[31:8];
    end else begin
      {r0, g0, b0} = px0[23:0];
      {r1, g1, b1} = px1[23:0];
    end
    y0 = bt709_component(r0, g0, b0, 47, 157, 16, 16);
    y1 = bt709_component(r1, g1, b1, 47, 157, 16, 16);
    // Chroma from the first pixel only
    u  = bt709_component(r0, g0, b0, -26, -87, 112, 128);
    v  = bt709_component(r0, g0, b0, 112, -102, -10, 128);
    if (dst == r2y422_pkg::DstYuyv) return {v, y1, u, y0};
    return {y1, v, y0, u};
  endfunction

  // Mostly random bytes, with a fair share of 0x00 and 0xFF
  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(7) == 0) px[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  // Offer one pair and hold it until accepted, then queue its word
  task automatic send_pair(input logic [31:0] px0, px1, input logic last);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {px1, px0};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    yuv_expected.push_back('{word: yuv422_word(px0, px1, src_order, dst_order), last: last});
  endtask

  // Stop sending and drain every outstanding word
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (yuv_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (index == r2y422_pkg::RegSourceOrder) src_order = data[0];
    else if (index == r2y422_pkg::RegDestOrder) dst_order = data[0];
  endtask

  // Reset orders first, then colour and alpha extremes
  task automatic test_directed_extremes();
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'h0000_FF00, 32'h00FF_0000, 1'b0);
    send_pair(32'h00FF_0000, 32'hFF00_0000, 1'b0);
    send_pair(32'hFF00_0000, 32'h0000_FF00, 1'b1);
    send_pair(32'h0000_00FF, 32'hFFFF_FF00, 1'b0);
    send_pair(32'hFFFF_FF00, 32'h0000_00FF, 1'b0);
    send_pair(32'h80FF_7F01, 32'h0180_FF7F, 1'b1);
  endtask

  // Every combination of byte orders, with stray upper data bits in the source order writes
  task automatic test_byte_orders();
    for (int k = 0; k < 4; k++) begin
      write_reg(r2y422_pkg::RegSourceOrder, k[0] ? 8'hFF : 8'hFE);
      write_reg(r2y422_pkg::RegDestOrder, k[1] ? 8'h01 : 8'h00);
      send_pair(32'h00FF_00FF, 32'hFF00_FF00, 1'b0);
      send_pair(32'h1234_5678, 32'h89AB_CDEF, 1'b1);
      send_pair(random_pixel(), random_pixel(), 1'b0);
    end
    // Writes beyond the register map are dropped
    write_reg(RegFirstUnused, 8'hFE);
    write_reg(RegLastIndex, 8'h00);
    send_pair(32'h00FF_00FF, 32'h12FF_8000, 1'b1);
  endtask

  task automatic test_random_stream();
    logic [6:0] stray;
    for (int phase = 0; phase < 4; phase++) begin
      stray = 7'($urandom_range(127));
      write_reg(r2y422_pkg::RegSourceOrder, {stray, phase[0]});
      stray = 7'($urandom_range(127));
      write_reg(r2y422_pkg::RegDestOrder, {stray, phase[1] ^ phase[0]});
      // Phase one runs back to back on both sides
      idle_on = (phase != 1);
      for (int i = 0; i < PhaseBeats; i++) begin
        if (phase == 2 && i == PhaseBeats / 2) wait_idle();
        send_pair(random_pixel(), random_pixel(), $urandom_range(7) == 0);
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls while idle_on is set, compare each accepted beat with the oldest expectation
  always @(posedge clk_i) begin
    yuv_beat_t exp_beat;
    if (rst_ni && m_tvalid && m_tready) begin
      if (yuv_expected.size() == 0) begin
        $error("unexpected result beat: packed_word %h last_word %b", m_tdata, m_tlast);
        error_count++;
      end else begin
        exp_beat = yuv_expected.pop_front();
        if (m_tdata !== exp_beat.word) begin
          $error("packed_word mismatch: expected %h, actual %h", exp_beat.word, m_tdata);
          error_count++;
        end
        if (m_tlast !== exp_beat.last) begin
          $error("last_word mismatch: expected %b, actual %b", exp_beat.last, m_tlast);
          error_count++;
        end
      end
    end
    m_tready <= idle_on ? ($urandom_range(99) >= IdlePercent) : 1'b1;
  end

  // Watchdog: give up after a long run of cycles with no beat or config write accepted
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    src_order   = r2y422_pkg::SrcArgb;
    dst_order   = r2y422_pkg::DstYuyv;
    idle_on     = 1'b1;
    error_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_byte_orders();
    test_random_stream();

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
